[sv/qpe_pkg.sv]
// ----------------------------------------------------------------------------
// Quadratic polynomial evaluator package
// Sizes, fixed-point formats, shared types and term-ordering helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpe_pkg;

	localparam int NUM_VARS   = 4;
	localparam int NUM_COEFFS = 15;
	localparam int FRAC_BITS  = 16;

	localparam int FIELD_VARS = 4;
	localparam int VAR_W      = 17;
	localparam int COEF_W     = 32;
	localparam int IDX_W      = 4;
	localparam int ACC_W      = 48;

	localparam int NUM_QUAD   = NUM_VARS * (NUM_VARS + 1) / 2;
	localparam int NUM_TERMS  = 1 + NUM_VARS + NUM_QUAD;
	localparam int GROUP      = 4;
	localparam int NUM_GROUPS = (NUM_TERMS + GROUP - 1) / GROUP;
	localparam int TERMS_PAD  = NUM_GROUPS * GROUP;

	localparam int P1_W = COEF_W + VAR_W + 1;
	localparam int T_W  = P1_W - FRAC_BITS;
	localparam int P2_W = T_W + VAR_W + 1;

	typedef enum logic [0:0] {
		OP_EVAL  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef logic        [VAR_W-1:0]  var_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [T_W-1:0]    prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef coef_t [NUM_COEFFS-1:0]   coef_arr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		coef_t            value;
	} coef_wr_t;

	function automatic int quad_i(int q);
		int n;
		int qi;
		n  = 0;
		qi = 0;
		for (int i = 0; i < NUM_VARS; i++) begin
			for (int j = 0; j <= i; j++) begin
				if (n == q) begin
					qi = i;
				end
				n++;
			end
		end
		return qi;
	endfunction

	function automatic int quad_j(int q);
		int n;
		int qj;
		n  = 0;
		qj = 0;
		for (int i = 0; i < NUM_VARS; i++) begin
			for (int j = 0; j <= i; j++) begin
				if (n == q) begin
					qj = j;
				end
				n++;
			end
		end
		return qj;
	endfunction

endpackage

[sv/quadratic_polynomial_eval.sv]
// An accepted evaluate beat passes stages s1, s2, s3 and s4 in turn; s4 drives the output.
// Throughput: one beat per cycle, evaluate or write, unless out_ready stalls the pipeline.
// A coefficient write takes effect for the next beat accepted after it.
// Reset empties the pipeline and clears every coefficient to zero at once.
// ----------------------------------------------------------------------------
// Quadratic polynomial evaluator
// Pipelined fixed-point evaluation of a full second-order polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_polynomial_eval import qpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [0:0]              op,
	input  logic [VAR_W-1:0]        var0,
	input  logic [VAR_W-1:0]        var1,
	input  logic [VAR_W-1:0]        var2,
	input  logic [VAR_W-1:0]        var3,
	input  logic [IDX_W-1:0]        coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [ACC_W-1:0] result
);

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic in_fire, eval_fire;
	logic ld2, ld3, ld4;

	coef_wr_t  wr;
	coef_arr_t coefs;
	var_t      fv [FIELD_VARS];
	var_t      x  [NUM_VARS];

	coef_t c0_s1;
	prod_t lin_s1  [NUM_VARS];
	prod_t quad_s1 [NUM_QUAD];
	var_t  x_s1    [NUM_VARS];
	acc_t  term_s2 [NUM_TERMS];
	acc_t  term_pad [TERMS_PAD];
	acc_t  grp_sum [NUM_GROUPS];
	acc_t  grp_s3  [NUM_GROUPS];
	acc_t  total;
	acc_t  result_s4;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_ready  = rdy1;
	assign in_fire   = in_valid && in_ready;
	assign eval_fire = in_fire && op == OP_EVAL;
	assign ld2       = v_s1 && rdy2;
	assign ld3       = v_s2 && rdy3;
	assign ld4       = v_s3 && rdy4;

	assign wr.en    = in_fire && op == OP_WRITE;
	assign wr.idx   = coef_index;
	assign wr.value = coef_value;

	qpe_coef_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.coefs  (coefs)
	);

	assign fv[0] = var0;
	assign fv[1] = var1;
	assign fv[2] = var2;
	assign fv[3] = var3;

	for (genvar i = 0; i < NUM_VARS; i++) begin : g_var
		if (i < FIELD_VARS) begin : g_field
			assign x[i] = fv[i];
		end else begin : g_zero
			assign x[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= eval_fire;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_fire) begin
			c0_s1 <= coefs[0];
		end
		if (ld2) begin
			term_s2[0] <= ACC_W'(c0_s1);
		end
	end

	for (genvar i = 0; i < NUM_VARS; i++) begin : g_lin
		localparam int K = 1 + i;
		coef_t                   c;
		logic signed [P1_W-1:0] p;

		if (K < NUM_COEFFS) begin : g_have
			assign c = coefs[K];
		end else begin : g_none
			assign c = '0;
		end

		assign p = P1_W'(c) * P1_W'($signed({1'b0, x[i]}));

		always_ff @(posedge clk) begin
			if (eval_fire) begin
				lin_s1[i] <= p[P1_W-1:FRAC_BITS];
				x_s1[i]   <= x[i];
			end
			if (ld2) begin
				term_s2[1 + i] <= ACC_W'(lin_s1[i]);
			end
		end
	end

	for (genvar q = 0; q < NUM_QUAD; q++) begin : g_quad
		localparam int K  = 1 + NUM_VARS + q;
		localparam int QI = quad_i(q);
		localparam int QJ = quad_j(q);
		coef_t                   c;
		logic signed [P1_W-1:0] p1;
		logic signed [P2_W-1:0] p2;

		if (K < NUM_COEFFS) begin : g_have
			assign c = coefs[K];
		end else begin : g_none
			assign c = '0;
		end

		assign p1 = P1_W'(c) * P1_W'($signed({1'b0, x[QI]}));
		assign p2 = P2_W'(quad_s1[q]) * P2_W'($signed({1'b0, x_s1[QJ]}));

		always_ff @(posedge clk) begin
			if (eval_fire) begin
				quad_s1[q] <= p1[P1_W-1:FRAC_BITS];
			end
			if (ld2) begin
				term_s2[K] <= ACC_W'($signed(p2[P2_W-1:FRAC_BITS]));
			end
		end
	end

	for (genvar t = 0; t < TERMS_PAD; t++) begin : g_pad
		if (t < NUM_TERMS) begin : g_term
			assign term_pad[t] = term_s2[t];
		end else begin : g_fill
			assign term_pad[t] = '0;
		end
	end

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
		always_comb begin
			grp_sum[g] = '0;
			for (int m = 0; m < GROUP; m++) begin
				grp_sum[g] = grp_sum[g] + term_pad[g * GROUP + m];
			end
		end

		always_ff @(posedge clk) begin
			if (ld3) begin
				grp_s3[g] <= grp_sum[g];
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			total = total + grp_s3[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			result_s4 <= total;
		end
	end

	assign out_valid = v_s4;
	assign result    = result_s4;

`ifndef SYNTHESIS
	a_write_no_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op == OP_WRITE) |=> !v_s1)
		else $error("write beat occupied the first stage");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy3) |=> v_s2)
		else $error("stalled item dropped from the second stage");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s4) |-> $past(v_s3))
		else $error("output became valid without an item behind it");
`endif

endmodule

[sv/qpe_coef_table.sv]
// ----------------------------------------------------------------------------
// Coefficient table
// Register file of signed coefficients with one write port, cleared at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpe_coef_table import qpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  coef_wr_t  wr,
	output coef_arr_t coefs
);

	coef_arr_t coef_q;

	for (genvar k = 0; k < NUM_COEFFS; k++) begin : g_entry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				coef_q[k] <= '0;
			end else if (wr.en && wr.idx == IDX_W'(k)) begin
				coef_q[k] <= wr.value;
			end
		end
	end

	assign coefs = coef_q;

`ifndef SYNTHESIS
	a_write_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && wr.idx < NUM_COEFFS) |=> coef_q[$past(wr.idx)] == $past(wr.value))
		else $error("coefficient write did not land");

	a_write_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && wr.idx >= NUM_COEFFS) |=> $stable(coef_q))
		else $error("out-of-range write changed the table");

	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!wr.en |=> $stable(coef_q))
		else $error("table changed without a write");
`endif

endmodule

[dv/quadratic_polynomial_eval_tb.sv]
// ----------------------------------------------------------------------------
// Quadratic polynomial evaluator testbench
// Drives coefficient writes and evaluate beats through a bursty sender. It
// predicts each polynomial value from its own coefficient table and checks
// every result, in order, against a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quadratic_polynomial_eval_tb import qpe_pkg::*;;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BEATS = 900;
	localparam int HOLD_CYCLES  = 150;
	localparam int SETTLE       = 20;

	typedef struct {
		op_t              op;
		var_t             vars [FIELD_VARS];
		logic [IDX_W-1:0] idx;
		coef_t            value;
	} beat_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [0:0]        op         = OP_EVAL;
	var_t              var0       = '0;
	var_t              var1       = '0;
	var_t              var2       = '0;
	var_t              var3       = '0;
	logic [IDX_W-1:0]  coef_index = '0;
	coef_t             coef_value = '0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	acc_t              result;

	beat_t pending_beats [$];
	acc_t  expected_results [$];
	coef_t coef_mirror [NUM_COEFFS];
	beat_t cur_beat;
	acc_t  want;
	int    mismatches  = 0;
	int    cycle_count = 0;
	int    beats_in    = 0;
	int    total_beats = 0;
	int    gap_left    = 0;
	int    burst_left  = 0;
	int    hold_left   = 0;
	int    holds_done  = 0;
	int    rx_mode     = 0;
	int    rx_phase    = 0;

	quadratic_polynomial_eval u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.var0       (var0),
		.var1       (var1),
		.var2       (var2),
		.var3       (var3),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what, acc_t got, acc_t exp_val);
		mismatches++;
		$display("ERROR at %0t: %s, got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	function automatic longint slot_value(int k);
		if (k >= NUM_COEFFS) begin
			return 0;
		end
		return longint'(coef_mirror[k]);
	endfunction

	// Every product is floored back to 16 fraction bits before it is used.
	function automatic acc_t poly_value(beat_t b);
		longint x [NUM_VARS];
		longint t;
		acc_t   acc;
		int     k;
		for (int i = 0; i < NUM_VARS; i++) begin
			x[i] = (i < FIELD_VARS) ? longint'(b.vars[i]) : 0;
		end
		acc = acc_t'(slot_value(0));
		k   = 1;
		for (int i = 0; i < NUM_VARS; i++) begin
			acc = acc + acc_t'((slot_value(k) * x[i]) >>> FRAC_BITS);
			k++;
		end
		for (int i = 0; i < NUM_VARS; i++) begin
			for (int j = 0; j <= i; j++) begin
				t   = (slot_value(k) * x[i]) >>> FRAC_BITS;
				acc = acc + acc_t'((t * x[j]) >>> FRAC_BITS);
				k++;
			end
		end
		return acc;
	endfunction

	function automatic var_t rand_var();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return var_t'($urandom_range(0, 65536));
		end else if (pick < 9) begin
			return var_t'($urandom());
		end
		case ($urandom_range(0, 2))
			0: return var_t'(0);
			1: return var_t'(65536);
			default: return var_t'(131071);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		if ($urandom_range(0, 1) == 0) begin
			return coef_t'($urandom());
		end
		return coef_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
	endfunction

	function automatic beat_t make_eval(var_t a, var_t b, var_t c, var_t d);
		beat_t e;
		e.op      = OP_EVAL;
		e.vars[0] = a;
		e.vars[1] = b;
		e.vars[2] = c;
		e.vars[3] = d;
		e.idx     = IDX_W'($urandom());
		e.value   = coef_t'($urandom());
		return e;
	endfunction

	function automatic beat_t make_write(int k, coef_t v);
		beat_t w;
		w.op    = OP_WRITE;
		for (int i = 0; i < FIELD_VARS; i++) begin
			w.vars[i] = var_t'($urandom());
		end
		w.idx   = IDX_W'(k);
		w.value = v;
		return w;
	endfunction

	initial begin
		for (int k = 0; k < NUM_COEFFS; k++) begin
			coef_mirror[k] = '0;
		end

		// Directed part: empty table, extreme coefficients in every slot, a write
		// past the end of the table, and variables at zero, one and full scale.
		pending_beats.push_back(make_eval(0, 0, 0, 0));
		pending_beats.push_back(make_eval(131071, 131071, 131071, 131071));
		for (int k = 0; k < NUM_COEFFS; k++) begin
			pending_beats.push_back(make_write(k, (k % 2 == 0) ? 32'sh7fffffff : 32'sh80000000));
		end
		pending_beats.push_back(make_write(15, 32'sh00012345));
		pending_beats.push_back(make_eval(65536, 65536, 65536, 65536));
		pending_beats.push_back(make_eval(131071, 131071, 131071, 131071));
		pending_beats.push_back(make_eval(0, 65536, 131071, 1));
		pending_beats.push_back(make_write(0, 32'sh00000000));
		pending_beats.push_back(make_eval(1, 1, 1, 1));

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				pending_beats.push_back(make_write($urandom_range(0, 15), rand_coef()));
			end else begin
				pending_beats.push_back(make_eval(rand_var(), rand_var(), rand_var(), rand_var()));
			end
		end
		total_beats = pending_beats.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_in < total_beats || expected_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sender: bursts of random length with random gaps, but no gaps while the
	// receiver is holding off so that the pipeline fills and stalls the input.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				beats_in <= beats_in + 1;
				if (cur_beat.op == OP_WRITE) begin
					if (cur_beat.idx < NUM_COEFFS) begin
						coef_mirror[cur_beat.idx] = cur_beat.value;
					end
				end else begin
					expected_results.push_back(poly_value(cur_beat));
				end
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 && hold_left == 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					cur_beat = pending_beats.pop_front();
					op         <= cur_beat.op;
					var0       <= cur_beat.vars[0];
					var1       <= cur_beat.vars[1];
					var2       <= cur_beat.vars[2];
					var3       <= cur_beat.vars[3];
					coef_index <= cur_beat.idx;
					coef_value <= cur_beat.value;
					in_valid   <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a stall mode redrawn each time its phase counter wraps, plus two long hold-offs.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done < 2 && beats_in >= 150 + holds_done * 450) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
			out_ready  <= 1'b0;
		end else begin
			if (rx_phase == 0) begin
				rx_mode <= $urandom_range(0, 2);
			end
			rx_phase <= (rx_phase == 49) ? 0 : rx_phase + 1;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", result, '0);
			end else begin
				want = expected_results.pop_front();
				if (result !== want) begin
					report_mismatch("result", result, want);
				end
			end
		end
	end

endmodule

[sim.f]
sv/qpe_pkg.sv
sv/qpe_coef_table.sv
sv/quadratic_polynomial_eval.sv
dv/quadratic_polynomial_eval_tb.sv
